>>> hw/rtl/bpms_pkg.sv
// Package for the byte pattern match scanner: sizes, register indexes and types.
`timescale 1ns / 1ps
`default_nettype none

package bpms_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int HIST_DEPTH        = MAX_PATTERN_BYTES - 1;
    localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W             = $clog2(MAX_PATTERN_BYTES);
    localparam int ADDR_W            = 64;
    localparam int COUNT_W           = 16;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 3;

    typedef logic [7:0]         byte_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LEN_W-1:0]   len_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_PATTERN_LEN  = 3'd2,
        REG_START_ADDR   = 3'd3,
        REG_END_ADDR     = 3'd4,
        REG_MAX_MATCHES  = 3'd5
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> hw/rtl/byte_pattern_match_scanner.sv
// Byte pattern match scanner: history shift register, pattern compare and match reporting.
//
//  channel | direction | signals
//  --------+-----------+------------------------------------------------
//  in      | sink      | in_valid, in_ready, data_byte, scan_start
//  out     | source    | out_valid, out_ready, match_address, match_number,
//          |           | limit_reached
//  cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One item a cycle unless the output register stalls: an item is registered in s1,
// then compared against the pattern and the history, and a match lands in the
// output register.
// The output register stalls the compare stage only while it holds an untaken item.
// Reset clears control state and loads the register reset values; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module byte_pattern_match_scanner
(
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [7:0]                       data_byte,
    input  wire                              scan_start,

    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [bpms_pkg::ADDR_W-1:0]      match_address,
    output logic [bpms_pkg::COUNT_W-1:0]     match_number,
    output logic                             limit_reached,

    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [bpms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [bpms_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bpms_pkg::*;

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    len_t                  pat_len_reg;
    addr_t                 start_addr_reg;
    addr_t                 end_addr_reg;
    count_t                max_matches_reg;

    logic                  s1_valid_reg;
    byte_t                 s1_byte_reg;
    logic                  s1_start_reg;

    byte_t                 recent_reg [HIST_DEPTH];
    byte_t                 recent_next [HIST_DEPTH];
    addr_t                 offset_reg;
    addr_t                 offset_next;
    len_t                  seen_reg;
    len_t                  seen_next;
    count_t                count_reg;
    count_t                count_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    addr_t                 match_address_reg;
    count_t                match_number_reg;
    logic                  limit_reached_reg;

    logic                  advance;
    logic                  hit;
    addr_t                 addr_cur;
    addr_t                 offset_cur;
    count_t                count_cur;
    count_t                count_inc;
    len_t                  seen_cur;
    len_t                  len_eff;
    logic                  take;
    byte_t                 hist [MAX_PATTERN_BYTES];
    logic [2*CFG_DATA_W-1:0] pattern;
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;

    assign cfg_ready     = 1'b1;
    assign advance       = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready      = !s1_valid_reg || advance;
    assign out_valid     = out_valid_reg;
    assign match_address = match_address_reg;
    assign match_number  = match_number_reg;
    assign limit_reached = limit_reached_reg;
    assign pattern       = {pat_high_reg, pat_low_reg};

    always_comb
    begin
        offset_cur = s1_start_reg ? '0 : offset_reg;
        count_cur  = s1_start_reg ? '0 : count_reg;
        seen_cur   = s1_start_reg ? '0 : seen_reg;
        addr_cur   = start_addr_reg + offset_cur;
        count_inc  = count_cur + count_t'(1);
        len_eff    = (pat_len_reg > len_t'(MAX_PATTERN_BYTES)) ? len_t'(MAX_PATTERN_BYTES)
                                                               : pat_len_reg;
        take       = (addr_cur < end_addr_reg) && (count_cur < max_matches_reg);
    end

    always_comb
    begin
        hist[0] = s1_byte_reg;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++)
        begin
            hist[j] = recent_reg[j-1];
        end
    end

    always_comb
    begin
        len_t pos;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            pos        = len_eff - len_t'(k) - len_t'(1);
            byte_ok[k] = (len_t'(k) >= len_eff)
                         || (pattern[8*k +: 8] == hist[pos[IDX_W-1:0]]);
        end
        hit = take && (len_eff != '0)
              && (({1'b0, seen_cur} + (LEN_W+1)'(1)) >= {1'b0, len_eff})
              && (&byte_ok);
    end

    always_comb
    begin
        offset_next = offset_cur + addr_t'(1);
        seen_next   = seen_cur;
        count_next  = hit ? count_inc : count_cur;
        recent_next = recent_reg;
        if (take)
        begin
            recent_next[0] = s1_byte_reg;
            for (int i = 1; i < HIST_DEPTH; i++)
            begin
                recent_next[i] = recent_reg[i-1];
            end
            if (seen_cur < len_t'(MAX_PATTERN_BYTES))
            begin
                seen_next = seen_cur + len_t'(1);
            end
        end
        if (advance && hit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg     <= '0;
            pat_high_reg    <= '0;
            pat_len_reg     <= len_t'(1);
            start_addr_reg  <= '0;
            end_addr_reg    <= '0;
            max_matches_reg <= count_t'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  pat_low_reg     <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg    <= cfg_data;
                REG_PATTERN_LEN:  pat_len_reg     <= cfg_data[LEN_W-1:0];
                REG_START_ADDR:   start_addr_reg  <= cfg_data[ADDR_W-1:0];
                REG_END_ADDR:     end_addr_reg    <= cfg_data[ADDR_W-1:0];
                REG_MAX_MATCHES:  max_matches_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_start_reg  <= 1'b0;
            offset_reg    <= '0;
            seen_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (in_valid && in_ready)
            begin
                s1_start_reg <= scan_start;
            end
            if (advance)
            begin
                offset_reg <= offset_next;
                seen_reg   <= seen_next;
                count_reg  <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: input byte, history, result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
        end
        if (advance)
        begin
            recent_reg <= recent_next;
        end
        if (advance && hit)
        begin
            match_address_reg <= addr_cur - addr_t'(len_eff - len_t'(1));
            match_number_reg  <= count_inc;
            limit_reached_reg <= (count_inc == max_matches_reg);
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_byte_pattern_match_scanner.sv
// Testbench for the byte pattern match scanner: directed and random scans, inline predictor.
`timescale 1ns / 1ps

module tb_byte_pattern_match_scanner;

    import bpms_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_BYTES   = 2000;
    localparam int LATENCY_CYCLES = 4;

    typedef struct packed {
        addr_t  addr;
        count_t number;
        logic   at_limit;
    } match_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    byte_t                 data_byte  = '0;
    logic                  scan_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    addr_t                 match_address;
    count_t                match_number;
    logic                  limit_reached;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index  = REG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    logic [63:0] pat_low    = '0;
    logic [63:0] pat_high   = '0;
    len_t        pat_len    = len_t'(1);
    addr_t       scan_base  = '0;
    addr_t       scan_limit = '0;
    count_t      match_cap  = count_t'(1);

    byte_t  history [HIST_DEPTH];
    addr_t  offset;
    len_t   seen;
    count_t found;

    match_t      pending_matches [$];
    int          errors      = 0;
    int unsigned hold_cycles = 0;
    int unsigned cycle_count = 0;
    bit          send_gaps   = 1'b1;
    bit          recv_gaps   = 1'b1;

    byte_pattern_match_scanner i_dut (.*);

    always #4 clk = ~clk;

    function automatic byte_t pattern_at(int k);
        logic [127:0] both;
        both = {pat_high, pat_low};
        return (k < MAX_PATTERN_BYTES) ? both[8*k +: 8] : 8'h00;
    endfunction

    function automatic void clear_scan();
        for (int i = 0; i < HIST_DEPTH; i++)
            history[i] = '0;
        offset = '0;
        seen   = '0;
        found  = '0;
    endfunction

    function automatic void scan_byte(byte_t value, logic first);
        addr_t  addr;
        int     len;
        logic   hit;
        byte_t  got;
        match_t m;
        if (first)
            clear_scan();
        addr = scan_base + offset;
        offset++;
        if (addr >= scan_limit || found >= match_cap)
            return;
        len = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len);
        hit = (len != 0) && (int'(seen) + 1 >= len);
        for (int k = 0; k < len; k++)
        begin
            got = (k == len - 1) ? value : history[len - 2 - k];
            if (got != pattern_at(k))
                hit = 1'b0;
        end
        for (int i = HIST_DEPTH - 1; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = value;
        if (seen < MAX_PATTERN_BYTES)
            seen++;
        if (hit)
        begin
            found++;
            m.addr     = addr - addr_t'(len - 1);
            m.number   = found;
            m.at_limit = (found == match_cap);
            pending_matches.push_back(m);
        end
    endfunction

    task automatic write_reg(cfg_reg_t index, logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_PATTERN_LOW:  pat_low    = value;
            REG_PATTERN_HIGH: pat_high   = value;
            REG_PATTERN_LEN:  pat_len    = len_t'(value);
            REG_START_ADDR:   scan_base  = value;
            REG_END_ADDR:     scan_limit = value;
            REG_MAX_MATCHES:  match_cap  = count_t'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [63:0] low, logic [63:0] high, int unsigned len,
                             logic [63:0] base, logic [63:0] limit, int unsigned cap);
        write_reg(REG_PATTERN_LOW, low);
        write_reg(REG_PATTERN_HIGH, high);
        write_reg(REG_PATTERN_LEN, 64'(len));
        write_reg(REG_START_ADDR, base);
        write_reg(REG_END_ADDR, limit);
        write_reg(REG_MAX_MATCHES, 64'(cap));
    endtask

    task automatic send_byte(byte_t value, logic first);
        @(negedge clk);
        while (send_gaps && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        scan_start <= first;
        do @(posedge clk); while (!in_ready);
        scan_byte(value, first);
    endtask

    // drain: drop valid, wait out every pending match and the pipeline
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_byte(8'h00, 1'b1);
        settle();
        write_reg(REG_END_ADDR, '1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        settle();
    endtask

    // sixteen-byte pattern across the address wrap, with a skipped top byte
    task automatic test_long_pattern();
        configure(64'hFFFF_FFFF_FFFF_FF00, '1, 31, 64'hFFFF_FFFF_FFFF_FFF6, '1, 65535);
        send_byte(8'h00, 1'b1);
        repeat (16) send_byte(8'hFF, 1'b0);
        settle();
    endtask

    task automatic test_length_and_limit();
        write_reg(REG_PATTERN_LEN, 64'd0);
        send_byte(8'hFF, 1'b0);
        settle();
        write_reg(REG_PATTERN_LEN, 64'd1);
        write_reg(REG_PATTERN_LOW, 64'h0);
        write_reg(REG_MAX_MATCHES, 64'd0);
        send_byte(8'h00, 1'b1);
        settle();
        write_reg(REG_PATTERN_LOW, 64'h5A);
        write_reg(REG_MAX_MATCHES, 64'd2);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h5A, 1'b0);
        settle();
    endtask

    task automatic pick_random_setup();
        logic [63:0] base;
        logic [63:0] limit;
        int unsigned len;
        int unsigned cap;
        base = ($urandom_range(3) == 0) ? ~64'($urandom_range(40)) : {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: limit = base + $urandom_range(20, 300);
            5, 6, 7:       limit = '1;
            8:             limit = {$urandom, $urandom};
            default:       limit = base + $urandom_range(8);
        endcase
        case ($urandom_range(19))
            0:       len = 0;
            1:       len = $urandom_range(17, 31);
            2, 3, 4: len = 16;
            default: len = $urandom_range(1, 16);
        endcase
        case ($urandom_range(15))
            0:       cap = 0;
            1:       cap = 65535;
            2:       cap = 1;
            default: cap = $urandom_range(2, 40);
        endcase
        configure({$urandom, $urandom}, {$urandom, $urandom}, len, base, limit, cap);
    endtask

    // mostly pattern bytes and whole pattern copies, some noise and stray scan starts
    task automatic send_scan(inout int unsigned sent);
        byte_t       queued [$];
        byte_t       value;
        int unsigned span;
        int unsigned len;
        span = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
        len  = (pat_len == 0) ? 1 : ((pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : pat_len);
        for (int n = 0; n < span; n++)
        begin
            if (queued.size() == 0 && $urandom_range(99) < 20)
                for (int k = 0; k < len; k++)
                    queued.push_back(pattern_at(k));
            if (queued.size() != 0)
                value = queued.pop_front();
            else if ($urandom_range(9) == 0)
                value = byte_t'($urandom);
            else
                value = pattern_at($urandom_range(len - 1));
            send_byte(value, (n == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
            sent++;
        end
    endtask

    task automatic test_random_scans();
        int unsigned sent;
        int unsigned phase;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES)
        begin
            pick_random_setup();
            send_gaps = (phase != 3);
            recv_gaps = (phase != 3);
            repeat ((phase == 3) ? 12 : $urandom_range(2, 6)) send_scan(sent);
            settle();
            phase++;
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // hold the output off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        configure(64'h3C, '0, 1, '0, '1, 65535);
        @(posedge clk);
        hold_cycles = 300;
        for (int i = 0; i < 40; i++)
            send_byte(8'h3C, i == 0);
        settle();
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= !(recv_gaps && $urandom_range(99) < 21);
            end
        end
    end

    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_matches.size() == 0)
            begin
                $display("%0t: match not expected, actual address %h number %0d limit %b",
                         $time, match_address, match_number, limit_reached);
                errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (match_address !== want.addr)
                begin
                    $display("%0t: match_address expected %h actual %h",
                             $time, want.addr, match_address);
                    errors++;
                end
                if (match_number !== want.number)
                begin
                    $display("%0t: match_number expected %0d actual %0d",
                             $time, want.number, match_number);
                    errors++;
                end
                if (limit_reached !== want.at_limit)
                begin
                    $display("%0t: limit_reached expected %b actual %b",
                             $time, want.at_limit, limit_reached);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[byte_pattern_match_scanner] ERROR");
        $finish;
    end

    initial
    begin
        clear_scan();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_long_pattern();
        test_length_and_limit();
        test_random_scans();
        test_backpressure();
        if (errors == 0)
            $display("[byte_pattern_match_scanner] OK");
        else
            $display("[byte_pattern_match_scanner] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/bpms_pkg.sv
hw/rtl/byte_pattern_match_scanner.sv
tb/tb_byte_pattern_match_scanner.sv
